>>> rtl/ekt_pkg.sv
// ekt_pkg: sizes, state codes and helpers for the expiring key table
// no dependencies; imported by expiring_key_table_core
`timescale 1ns / 1ps

package ekt_pkg;

	localparam int TABLE_DEPTH = 32;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int KEY_W       = 16;
	localparam int DUR_W       = 24;
	localparam int TIME_W      = 32;
	localparam int LIVE_W      = 6;
	localparam int EXT_W       = (CNT_W > LIVE_W) ? CNT_W : LIVE_W;
	localparam int ENTRY_W     = KEY_W + TIME_W;
	localparam int IN_DATA_W   = 72;
	localparam int OUT_DATA_W  = 8;

	localparam logic ACT_ADD   = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SWEEP  = 2'd1;
	localparam logic [1:0] ST_FINISH = 2'd2;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [TIME_W-1:0] expiry;
	} entry_t;

	function automatic logic [LIVE_W-1:0] sat_live(input logic [EXT_W-1:0] cnt);
		logic [EXT_W-1:0] lim;
		lim = EXT_W'(63);
		if (cnt > lim)
			return LIVE_W'(63);
		else
			return cnt[LIVE_W-1:0];
	endfunction

endpackage

>>> rtl/expiring_key_table_core.sv
// expiring_key_table_core: fixed-capacity key table with expiry, one sweep per word
// depends on ekt_pkg; entries in an internal synchronous memory, valid bits in flops
`timescale 1ns / 1ps
//
//  channel  | direction | tdata (low bit up)                       | tuser
//  s_axis   | in        | entry_key[15:0] duration[23:0] now[31:0] | action
//  m_axis   | out       | ok, live_count[5:0], zero pad            | -
//
//  per word, one memory read port walks every entry once and the last read drains;
//  the finish step, held until any older result is taken, writes the new entry and loads the result
//  the result register holds until taken; the next word is accepted meanwhile
//  reset clears the valid bits at once, no clearing pass

module expiring_key_table_core
	import ekt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // entry_key, duration, now_time
	input  logic [0:0]            s_axis_tuser,   // action
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata    // ok, live_count, pad
);

	entry_t                   mem [TABLE_DEPTH];
	entry_t                   rd_data_s1;
	logic                     rd_vld_s1;
	idx_t                     idx_s1;

	logic [1:0]               state_q;
	idx_t                     rd_idx_q;
	logic [TABLE_DEPTH-1:0]   valid_q;
	logic                     act_q;
	logic [KEY_W-1:0]         key_q;
	logic [DUR_W-1:0]         dur_q;
	logic [TIME_W-1:0]        now_q;
	logic                     found_q;
	logic                     free_found_q;
	idx_t                     free_idx_q;
	cnt_t                     live_cnt_q;

	logic                     out_vld_q;
	logic                     ok_q;
	logic [LIVE_W-1:0]        live_q;

	logic                     in_acc;
	logic                     rd_en;
	logic                     cur_valid;
	logic                     expired;
	logic                     keep;
	logic                     finish;
	logic                     stored;
	entry_t                   wr_entry;
	cnt_t                     live_final;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign rd_en         = (state_q == ST_SWEEP);

	assign cur_valid = valid_q[idx_s1];
	assign expired   = cur_valid && (now_q > rd_data_s1.expiry);
	assign keep      = cur_valid && !expired;

	assign finish     = (state_q == ST_FINISH) && !rd_vld_s1 && (!out_vld_q || m_axis_tready);
	assign stored     = (act_q == ACT_ADD) && free_found_q;
	assign live_final = live_cnt_q + cnt_t'(stored);

	assign wr_entry.key    = key_q;
	assign wr_entry.expiry = now_q + TIME_W'(dur_q);

	// table memory
	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data_s1 <= mem[rd_idx_q];
		if (finish && stored)
			mem[free_idx_q] <= wr_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			rd_idx_q     <= '0;
			rd_vld_s1    <= 1'b0;
			idx_s1       <= '0;
			valid_q      <= '0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			live_cnt_q   <= '0;
			out_vld_q    <= 1'b0;
			ok_q         <= 1'b0;
			live_q       <= '0;
			act_q        <= ACT_ADD;
			key_q        <= '0;
			dur_q        <= '0;
			now_q        <= '0;
		end else begin
			rd_vld_s1 <= rd_en;
			idx_s1    <= rd_idx_q;

			if (finish)
				out_vld_q <= 1'b1;
			else if (m_axis_tready)
				out_vld_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						act_q        <= s_axis_tuser[0];
						key_q        <= s_axis_tdata[KEY_W-1:0];
						dur_q        <= s_axis_tdata[KEY_W+DUR_W-1:KEY_W];
						now_q        <= s_axis_tdata[KEY_W+DUR_W+TIME_W-1:KEY_W+DUR_W];
						rd_idx_q     <= '0;
						found_q      <= 1'b0;
						free_found_q <= 1'b0;
						live_cnt_q   <= '0;
						state_q      <= ST_SWEEP;
					end
				end
				ST_SWEEP: begin
					if (rd_idx_q == idx_t'(TABLE_DEPTH - 1))
						state_q <= ST_FINISH;
					else
						rd_idx_q <= rd_idx_q + idx_t'(1);
				end
				ST_FINISH: begin
					if (finish) begin
						if (stored)
							valid_q[free_idx_q] <= 1'b1;
						ok_q      <= (act_q == ACT_ADD) ? free_found_q : found_q;
						live_q    <= sat_live(EXT_W'(live_final));
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// per-entry update as read data returns
			if (rd_vld_s1) begin
				if (expired)
					valid_q[idx_s1] <= 1'b0;
				if (keep) begin
					live_cnt_q <= live_cnt_q + cnt_t'(1);
					if ((act_q == ACT_QUERY) && (rd_data_s1.key == key_q))
						found_q <= 1'b1;
				end else if (!free_found_q) begin
					free_found_q <= 1'b1;
					free_idx_q   <= idx_s1;
				end
			end
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {{(OUT_DATA_W - 1 - LIVE_W){1'b0}}, live_q, ok_q};

endmodule

>>> bench/expiring_key_table_core_test.sv
// expiring_key_table_core_test: self-checking bench for the expiring key table core
// drives adds and queries over the stream ports and checks ok and live_count per word
// depends on ekt_pkg and expiring_key_table_core
`timescale 1ns / 1ps

module expiring_key_table_core_test;
	import ekt_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = TABLE_DEPTH + 8;
	localparam int WORDS_PER_MODE = 430;

	typedef struct packed {
		logic              ok;
		logic [LIVE_W-1:0] live_count;
	} table_result_t;

	class expiry_table_scoreboard;
		logic [KEY_W-1:0]  slot_key [TABLE_DEPTH];
		logic [TIME_W-1:0] slot_expiry [TABLE_DEPTH];
		bit                slot_live [TABLE_DEPTH];
		table_result_t     pending_results [$];
		int errors;
		int results_seen;
		int adds_stored;
		int adds_refused;
		int queries_found;
		int queries_missed;
		int peak_live;

		function new();
			foreach (slot_live[i])
				slot_live[i] = 1'b0;
			errors = 0;
			results_seen = 0;
			adds_stored = 0;
			adds_refused = 0;
			queries_found = 0;
			queries_missed = 0;
			peak_live = 0;
		endfunction

		function void note_word(input logic action, input logic [KEY_W-1:0] key,
			input logic [DUR_W-1:0] dur, input logic [TIME_W-1:0] now);
			table_result_t res;
			int live;
			res.ok = 1'b0;
			live = 0;
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				if (slot_live[i] && now > slot_expiry[i])
					slot_live[i] = 1'b0;
			end
			if (action == ACT_ADD) begin
				for (int i = 0; i < TABLE_DEPTH; i++) begin
					if (!slot_live[i]) begin
						slot_key[i] = key;
						slot_expiry[i] = now + TIME_W'(dur);
						slot_live[i] = 1'b1;
						res.ok = 1'b1;
						break;
					end
				end
				if (res.ok)
					adds_stored++;
				else
					adds_refused++;
			end else begin
				for (int i = 0; i < TABLE_DEPTH; i++) begin
					if (slot_live[i] && slot_key[i] == key) begin
						res.ok = 1'b1;
						break;
					end
				end
				if (res.ok)
					queries_found++;
				else
					queries_missed++;
			end
			foreach (slot_live[i])
				live += slot_live[i];
			if (live > peak_live)
				peak_live = live;
			if (live > 63)
				live = 63;
			res.live_count = LIVE_W'(live);
			pending_results.push_back(res);
		endfunction

		function void check_result(input logic ok, input logic [LIVE_W-1:0] live_count);
			table_result_t want;
			results_seen++;
			if (pending_results.size() == 0) begin
				$error("result word with nothing expected: ok=%0d live_count=%0d",
					ok, live_count);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			if (ok !== want.ok) begin
				$error("ok mismatch: expected %0d, actual %0d", want.ok, ok);
				errors++;
			end
			if (live_count !== want.live_count) begin
				$error("live_count mismatch: expected %0d, actual %0d",
					want.live_count, live_count);
				errors++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic [0:0]            s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	expiry_table_scoreboard ledger = new();
	int send_idle_pct;
	int recv_stall_pct;
	int quiet_cycles;
	int words_sent;
	logic [TIME_W-1:0] sim_now;

	expiring_key_table_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			ledger.check_result(m_axis_tdata[0], m_axis_tdata[LIVE_W:1]);
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (arst_n) begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	task automatic send_word(input logic action, input logic [KEY_W-1:0] key,
		input logic [DUR_W-1:0] dur, input logic [TIME_W-1:0] now);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {now, dur, key};
		s_axis_tuser  <= action;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		ledger.note_word(action, key, dur, now);
		words_sent++;
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		if ($urandom_range(99) < 80)
			return KEY_W'($urandom_range(7));
		return KEY_W'($urandom);
	endfunction

	task automatic run_traffic(input int count);
		int n;
		int pick;
		int burst;
		logic [KEY_W-1:0] key;
		logic [DUR_W-1:0] dur;
		n = 0;
		while (n < count) begin
			pick = $urandom_range(99);
			if (pick < 8) begin
				// fill past capacity at a frozen time so later adds get refused
				burst = $urandom_range(TABLE_DEPTH + 1, TABLE_DEPTH + 8);
				for (int j = 0; j < burst; j++)
					send_word(ACT_ADD, pick_key(), DUR_W'($urandom_range(100, 400)), sim_now);
				n += burst;
			end else if (pick < 12) begin
				if ($urandom_range(1))
					sim_now = $urandom;
				else
					sim_now = '1 - TIME_W'($urandom_range(200));
				send_word(ACT_ADD, pick_key(), DUR_W'($urandom), sim_now);
				n++;
			end else if (pick < 16) begin
				// probe the boundary: live at expiry, gone one time unit later
				key = pick_key();
				dur = DUR_W'($urandom_range(50));
				send_word(ACT_ADD, key, dur, sim_now);
				send_word(ACT_QUERY, key, DUR_W'($urandom), sim_now + TIME_W'(dur));
				send_word(ACT_QUERY, key, DUR_W'($urandom), sim_now + TIME_W'(dur) + 1);
				sim_now = sim_now + TIME_W'(dur) + 1;
				n += 3;
			end else begin
				sim_now = sim_now + TIME_W'($urandom_range(3));
				if ($urandom_range(99) < 85)
					dur = DUR_W'($urandom_range(80));
				else
					dur = DUR_W'($urandom);
				send_word($urandom_range(1) ? ACT_QUERY : ACT_ADD, pick_key(), dur, sim_now);
				n++;
			end
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		s_axis_tuser   = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		words_sent     = 0;
		sim_now        = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, expiry equal to now, wrapped expiry, duplicates
		send_word(ACT_QUERY, 16'h0000, 24'h000000, 32'h0000_0000);
		send_word(ACT_ADD,   16'hFFFF, 24'h000000, 32'hFFFF_FFFE);
		send_word(ACT_QUERY, 16'hFFFF, 24'hFFFFFF, 32'hFFFF_FFFE);
		send_word(ACT_QUERY, 16'hFFFF, 24'h000000, 32'hFFFF_FFFF);
		send_word(ACT_ADD,   16'h1234, 24'hFFFFFF, 32'hFFFF_FF00);
		send_word(ACT_QUERY, 16'h1234, 24'h000000, 32'hFFFF_FF00);
		send_word(ACT_ADD,   16'h0000, 24'h00000A, 32'h0000_0000);
		send_word(ACT_ADD,   16'h0000, 24'h00000A, 32'h0000_0000);
		send_word(ACT_QUERY, 16'h0000, 24'h000000, 32'h0000_000A);
		send_word(ACT_QUERY, 16'h0000, 24'h000000, 32'h0000_000B);
		send_word(ACT_ADD,   16'hAAAA, 24'h555555, 32'h5555_5555);
		send_word(ACT_QUERY, 16'hAAAA, 24'hAAAAAA, 32'h5555_5555);
		send_word(ACT_ADD,   16'h5555, 24'hAAAAAA, 32'hAAAA_AAAA);
		send_word(ACT_QUERY, 16'h5555, 24'h555555, 32'hAAAA_AAAA);
		send_word(ACT_QUERY, 16'h5556, 24'h000000, 32'hAAAA_AAAA);
		send_word(ACT_QUERY, 16'hAAAA, 24'h000000, 32'hFFFF_FFFF);
		sim_now = 32'd1000;

		send_idle_pct = 0;  recv_stall_pct = 0;
		run_traffic(WORDS_PER_MODE);
		send_idle_pct = 55; recv_stall_pct = 0;
		run_traffic(WORDS_PER_MODE);
		send_idle_pct = 0;  recv_stall_pct = 55;
		run_traffic(WORDS_PER_MODE);
		send_idle_pct = 24; recv_stall_pct = 24;
		run_traffic(WORDS_PER_MODE);
		s_axis_tvalid <= 1'b0;

		while (ledger.pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d words, checked %0d results; peak occupancy %0d of %0d",
			words_sent, ledger.results_seen, ledger.peak_live, TABLE_DEPTH);
		$display("adds stored %0d, refused when full %0d; queries hit %0d, missed %0d",
			ledger.adds_stored, ledger.adds_refused, ledger.queries_found,
			ledger.queries_missed);
		if (ledger.errors == 0 && ledger.pending_results.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
